### rtl/csc_pkg.sv
// Shared constants, types and elaboration-time tables for the cosine series checker.
`default_nettype none
package csc_pkg;

   localparam int FRAC_BITS    = 40;
   localparam int CORDIC_STEPS = 40;
   localparam int COUNT_BITS   = 14;
   localparam int X_W          = FRAC_BITS + 3;
   localparam int TOL_W        = FRAC_BITS + 1;
   localparam int REF_W        = FRAC_BITS + 2;
   localparam int SUM_W        = FRAC_BITS + 7;
   localparam int Z_W          = 45;
   localparam int CB           = 60;
   localparam int CSR_IDX_W    = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_TERM_COUNT = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE  = 4'd1;

   localparam logic [COUNT_BITS-1:0] TERM_COUNT_RST = 14'd10000;
   localparam logic [TOL_W-1:0]      TOLERANCE_RST  = 41'd10995;

   typedef logic signed [Z_W-1:0] angle_arr_type [CORDIC_STEPS];

   // unsigned quotient by shift and subtract, both operands non-negative
   function automatic longint udiv(longint num, longint den);
      logic [63:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = 64'(num);
      for (int b = 0; b < 64; b++) begin
         rem = {rem[62:0], quo[63]};
         quo = {quo[62:0], 1'b0};
         if (rem >= 64'(den)) begin
            rem    = rem - 64'(den);
            quo[0] = 1'b1;
         end
      end
      return longint'(quo);
   endfunction

   function automatic longint atan_inv5();
      longint p;
      longint s;
      longint t;
      p = udiv(longint'(1) <<< CB, 5);
      s = 0;
      for (int n = 0; n < 32; n++) begin
         if (p != 0) begin
            t = udiv(p, longint'(2 * n + 1));
            s = n[0] ? s - t : s + t;
            p = udiv(p, 25);
         end
      end
      return s;
   endfunction

   function automatic longint atan_inv239();
      longint p;
      longint s;
      longint t;
      p = udiv(longint'(1) <<< CB, 239);
      s = 0;
      for (int n = 0; n < 32; n++) begin
         if (p != 0) begin
            t = udiv(p, longint'(2 * n + 1));
            s = n[0] ? s - t : s + t;
            p = udiv(p, 57121);
         end
      end
      return s;
   endfunction

   function automatic longint atan_pow2(int i);
      longint s;
      longint t;
      s = 0;
      for (int n = 0; n < 32; n++) begin
         if (i * (2 * n + 1) <= CB) begin
            t = udiv(longint'(1) <<< (CB - i * (2 * n + 1)), longint'(2 * n + 1));
            s = n[0] ? s - t : s + t;
         end
      end
      return s;
   endfunction

   function automatic longint inv_one_plus(int i);
      longint s;
      s = 0;
      if (i == 0) begin
         s = longint'(1) <<< (CB - 1);
      end else begin
         for (int n = 0; n <= CB; n++) begin
            if (2 * n * i <= CB) begin
               s = n[0] ? s - (longint'(1) <<< (CB - 2 * n * i))
                        : s + (longint'(1) <<< (CB - 2 * n * i));
            end
         end
      end
      return s;
   endfunction

   function automatic longint to_frac(longint v);
      return (v + (longint'(1) <<< (CB - FRAC_BITS - 1))) >>> (CB - FRAC_BITS);
   endfunction

   function automatic logic [63:0] build_k2();
      logic [127:0] p;
      logic [63:0]  k;
      k = 64'd1 << CB;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         p = {64'd0, k} * {64'd0, 64'(inv_one_plus(i))};
         k = p[CB +: 64];
      end
      return k;
   endfunction

   function automatic angle_arr_type build_angles();
      angle_arr_type a;
      longint pi4;
      pi4 = 4 * atan_inv5() - atan_inv239();
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         a[i] = (i == 0) ? Z_W'(to_frac(pi4)) : Z_W'(to_frac(atan_pow2(i)));
      end
      return a;
   endfunction

   localparam longint PI4_C = 4 * atan_inv5() - atan_inv239();
   localparam logic signed [Z_W-1:0] PI_F      = Z_W'(to_frac(4 * PI4_C));
   localparam logic signed [Z_W-1:0] HALF_PI_F = Z_W'(to_frac(2 * PI4_C));
   localparam logic [63:0]           K2_C      = build_k2();
   localparam angle_arr_type         ANGLE     = build_angles();

endpackage
`default_nettype wire

### rtl/cosine_series_convergence.sv
// Top level: CORDIC reference and Maclaurin series check of cos(2x)-1 on one shared sequencer.
`default_nettype none
// Each beat on req carries x (signed Q.40). The block forms ref = 2*cos(x)^2 - 2 with a
// 40-step CORDIC, then sums the series for cos(2x)-1 over term_count terms and reports
// the sum (saturated to 47 bits) and the first term index whose partial sum lies within
// tolerance of ref (0 if none). One item is worked at a time and req_tready is low while
// it runs. Work starts with the 40-step CORDIC and three shift-add multiplies, then each later
// term forms 2k(2k-1), takes the bit-serial quotient q/(2k(2k-1)), loads the multiplier,
// runs the shift-add product, and then takes the product, accumulates and compares. The
// loop ends at term_count or at the first zero term, so the largest arguments need about
// 23 terms, and x = 0 finishes after one term. The result waits in an output register;
// the next item is taken once the result is loaded there. Configuration writes are taken
// at any time (csr_ready is always high) but are meant for idle periods only.
module cosine_series_convergence
   import csc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [47:0]          req_tdata,   // [42:0] x_value, rest zero
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [103:0]              rsp_tdata,   // [41:0] ref_value, [88:42] series_sum,
                                                  // [102:89] converge_index, rest zero
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [TOL_W-1:0]     csr_data
);

   localparam int MUL_W  = 60;
   localparam int C_W    = 44;
   localparam int Q_W    = 48;
   localparam int T_W    = 56;
   localparam int S_W    = 58;
   localparam int D_W    = 60;
   localparam int DEN_W  = 30;

   typedef enum logic [3:0] {
      S_IDLE, S_CORDIC, S_SQ, S_MUL, S_MRES, S_ACC, S_TEST, S_DEN, S_DIV, S_DRES, S_DONE
   } state_type;

   typedef enum logic [1:0] {OP_XX, OP_C2, OP_Q, OP_TERM} op_type;

   state_type                state_ff, state_in;
   op_type                   op_ff, op_in;
   logic [5:0]               cnt_ff, cnt_in;
   logic signed [X_W-1:0]    x_ff, x_in;
   logic signed [Z_W-1:0]    z_ff, z_in;
   logic signed [C_W-1:0]    cx_ff, cx_in, cy_ff, cy_in;
   logic [MUL_W-1:0]         acc_ff, acc_in, mlo_ff, mlo_in, mul_a_ff, mul_a_in;
   logic                     neg_ff, neg_in;
   logic [REF_W-1:0]         y_ff, y_in;
   logic [Q_W-1:0]           q_ff, q_in, dq_ff, dq_in;
   logic signed [T_W-1:0]    term_ff, term_in;
   logic signed [S_W-1:0]    sum_ff, sum_in;
   logic [COUNT_BITS-1:0]    k_ff, k_in, found_ff, found_in;
   logic [DEN_W-1:0]         den_ff, den_in, rem_ff, rem_in;
   logic [COUNT_BITS-1:0]    count_cfg_ff, count_cfg_in;
   logic [TOL_W-1:0]         tol_ff, tol_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [103:0]             rsp_data_ff, rsp_data_in;

   // scratch
   logic signed [Z_W-1:0]    xs, ax;
   logic signed [C_W-1:0]    dx, dy, cx_abs;
   logic [MUL_W:0]           mul_sum;
   logic [2*MUL_W-1:0]       prod;
   logic [43:0]              xx;
   logic [44:0]              c2w;
   logic [40:0]              c2;
   logic [42:0]              yt;
   logic signed [44:0]       tx, tx_abs;
   logic [T_W-1:0]           mm;
   logic signed [D_W-1:0]    diff, ad;
   logic [14:0]              kk;
   logic [DEN_W:0]           rem_sh;
   logic                     ge;
   logic signed [SUM_W-1:0]  sum_sat;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      cnt_in       = cnt_ff;
      x_in         = x_ff;
      z_in         = z_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      acc_in       = acc_ff;
      mlo_in       = mlo_ff;
      mul_a_in     = mul_a_ff;
      neg_in       = neg_ff;
      y_in         = y_ff;
      q_in         = q_ff;
      dq_in        = dq_ff;
      term_in      = term_ff;
      sum_in       = sum_ff;
      k_in         = k_ff;
      found_in     = found_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      count_cfg_in = count_cfg_ff;
      tol_in       = tol_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      xs      = Z_W'(x_ff);
      ax      = '0;
      dx      = cy_ff >>> cnt_ff;
      dy      = cx_ff >>> cnt_ff;
      cx_abs  = cx_ff[C_W-1] ? -cx_ff : cx_ff;
      mul_sum = {1'b0, acc_ff} + (mlo_ff[0] ? {1'b0, mul_a_ff} : '0);
      prod    = {acc_ff, mlo_ff};
      xx      = prod[FRAC_BITS +: 44];
      c2w     = prod[CB +: 45];
      c2      = (c2w > 45'(64'd1 << FRAC_BITS)) ? 41'(64'd1 << FRAC_BITS) : c2w[40:0];
      yt      = {1'b0, c2, 1'b0} - (43'd1 << (FRAC_BITS + 1));
      tx      = {x_ff[X_W-1], x_ff, 1'b0};
      tx_abs  = tx[44] ? -tx : tx;
      mm      = prod[FRAC_BITS +: T_W] + T_W'(neg_ff && (|prod[FRAC_BITS-1:0]));
      diff    = D_W'(signed'(y_ff)) - D_W'(sum_ff);
      ad      = diff[D_W-1] ? -diff : diff;
      kk      = {k_ff, 1'b0};
      rem_sh  = {rem_ff, dq_ff[Q_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      if (sum_ff > S_W'(signed'({1'b0, {(SUM_W-1){1'b1}}}))) begin
         sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
      end else if (sum_ff < -S_W'(signed'({1'b0, {(SUM_W-1){1'b1}}})) - S_W'(1)) begin
         sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
      end else begin
         sum_sat = sum_ff[SUM_W-1:0];
      end

      // configuration beats
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TERM_COUNT: count_cfg_in = csr_data[COUNT_BITS-1:0];
            CSR_TOLERANCE:  tol_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               x_in   = req_tdata[X_W-1:0];
               xs     = Z_W'(signed'(req_tdata[X_W-1:0]));
               ax     = xs[Z_W-1] ? -xs : xs;
               // fold large arguments: cos^2 is the same at pi-|x|
               z_in   = (ax > HALF_PI_F) ? PI_F - ax : ax;
               cx_in  = C_W'(64'd1 << FRAC_BITS);
               cy_in  = '0;
               cnt_in = '0;
               state_in = S_CORDIC;
            end
         end
         S_CORDIC: begin
            if (!z_ff[Z_W-1]) begin
               cx_in = cx_ff - dx;
               cy_in = cy_ff + dy;
               z_in  = z_ff - ANGLE[cnt_ff];
            end else begin
               cx_in = cx_ff + dx;
               cy_in = cy_ff - dy;
               z_in  = z_ff + ANGLE[cnt_ff];
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(CORDIC_STEPS - 1)) begin
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            mul_a_in = MUL_W'(unsigned'(cx_abs));
            mlo_in   = MUL_W'(unsigned'(cx_abs));
            acc_in   = '0;
            cnt_in   = '0;
            op_in    = OP_XX;
            state_in = S_MUL;
         end
         S_MUL: begin
            acc_in = mul_sum[MUL_W:1];
            mlo_in = {mul_sum[0], mlo_ff[MUL_W-1:1]};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(MUL_W - 1)) begin
               state_in = S_MRES;
            end
         end
         S_MRES: begin
            acc_in = '0;
            cnt_in = '0;
            unique case (op_ff)
               OP_XX: begin
                  mul_a_in = MUL_W'(xx);
                  mlo_in   = K2_C[MUL_W-1:0];
                  op_in    = OP_C2;
                  state_in = S_MUL;
               end
               OP_C2: begin
                  y_in     = yt[REF_W-1:0];
                  mul_a_in = MUL_W'(unsigned'(tx_abs));
                  mlo_in   = MUL_W'(unsigned'(tx_abs));
                  op_in    = OP_Q;
                  state_in = S_MUL;
               end
               OP_Q: begin
                  q_in     = prod[FRAC_BITS +: Q_W];
                  k_in     = COUNT_BITS'(1);
                  found_in = '0;
                  sum_in   = '0;
                  term_in  = -T_W'(signed'({1'b0, prod[FRAC_BITS+1 +: Q_W-1]}));
                  state_in = (count_cfg_ff == '0) ? S_DONE : S_ACC;
               end
               OP_TERM: begin
                  term_in  = neg_ff ? -signed'(mm) : signed'(mm);
                  state_in = S_ACC;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_ACC: begin
            sum_in   = sum_ff + S_W'(term_ff);
            state_in = S_TEST;
         end
         S_TEST: begin
            if (found_ff == '0 && ad < D_W'(tol_ff)) begin
               found_in = k_ff;
            end
            // stop at the configured count or once the terms have vanished
            if (term_ff == '0 || k_ff == count_cfg_ff) begin
               state_in = S_DONE;
            end else begin
               k_in     = k_ff + COUNT_BITS'(1);
               state_in = S_DEN;
            end
         end
         S_DEN: begin
            den_in   = DEN_W'(kk) * DEN_W'(kk - 15'd1);
            rem_in   = '0;
            dq_in    = q_ff;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in = ge ? DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DEN_W-1:0];
            dq_in  = {dq_ff[Q_W-2:0], ge};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(Q_W - 1)) begin
               state_in = S_DRES;
            end
         end
         S_DRES: begin
            // term * -(q/den): the ratio is negative, so flip the sign of term
            mul_a_in = MUL_W'(unsigned'(term_ff[T_W-1] ? -term_ff : term_ff));
            mlo_in   = MUL_W'(dq_ff);
            neg_in   = !term_ff[T_W-1];
            acc_in   = '0;
            cnt_in   = '0;
            op_in    = OP_TERM;
            state_in = S_MUL;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {1'b0, found_ff, sum_sat, y_ff};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      cnt_ff      <= cnt_in;
      x_ff        <= x_in;
      z_ff        <= z_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      acc_ff      <= acc_in;
      mlo_ff      <= mlo_in;
      mul_a_ff    <= mul_a_in;
      neg_ff      <= neg_in;
      y_ff        <= y_in;
      q_ff        <= q_in;
      dq_ff       <= dq_in;
      term_ff     <= term_in;
      sum_ff      <= sum_in;
      k_ff        <= k_in;
      found_ff    <= found_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_cfg_ff <= TERM_COUNT_RST;
         tol_ff       <= TOLERANCE_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_cfg_ff <= count_cfg_in;
         tol_ff       <= tol_in;
      end
   end

   a_cordic_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CORDIC |-> cnt_ff < 6'(CORDIC_STEPS))
      else $error("CORDIC step counter past last step");

   a_found_le_k: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_TEST |-> (found_ff == '0 || found_ff <= k_ff))
      else $error("convergence index ahead of term index");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> den_ff != '0)
      else $error("divide started with zero denominator");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result raised outside completion");

endmodule
`default_nettype wire
